@@ src/ohm_pkg.sv @@
// Package for the open-addressing hash map: sizes, codes, shared types.
// Depends on nothing; used by ohm_front, ohm_back and the top level.
package ohm_pkg;
  localparam int SLOTS = 256;
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int VALUE_WIDTH = 64;
  localparam int CNT_W = SLOT_W + 1;
  localparam logic [63:0] FNV_BASIS = 64'hCBF29CE484222325;
  localparam logic [63:0] FNV_PRIME = 64'h00000100000001B3;
  // The prime is 2**FNV_PRIME_SHIFT plus FNV_PRIME_LOW.
  localparam int FNV_PRIME_SHIFT = 40;
  localparam logic [8:0] FNV_PRIME_LOW = 9'h1B3;
  localparam logic [2:0] ACT_GET = 3'd0;
  localparam logic [2:0] ACT_SET = 3'd1;
  localparam logic [2:0] ACT_DEL = 3'd2;
  localparam logic [2:0] ACT_RST = 3'd3;
  localparam logic [2:0] ACT_NEXT = 3'd4;
  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_NOTFOUND = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;
  localparam logic [1:0] ST_END = 2'd3;
  localparam logic [1:0] MARK_EMPTY = 2'd0;
  localparam logic [1:0] MARK_LIVE = 2'd1;
  localparam logic [1:0] MARK_TOMB = 2'd2;

  typedef struct packed {
    logic [2:0] action;
    logic [63:0] key;
    logic [VALUE_WIDTH-1:0] value;
    logic [SLOT_W-1:0] home;
  } cmd_t;
endpackage

@@ src/ohm_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read.
// Depends on nothing.
module ohm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic clk,
  input  logic we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ src/ohm_front.sv @@
// Front part: masks the key and, for get, set and delete, hashes it byte-serially with FNV-1a-64.
// Depends on ohm_pkg.
module ohm_front (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  input  logic [2:0] action,
  input  logic [63:0] key,
  input  logic [63:0] value,
  input  logic [3:0] key_bytes,
  output logic q_valid,
  input  logic q_ready,
  output ohm_pkg::cmd_t q_cmd
);
  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_XOR = 2'd1;
  localparam logic [1:0] F_MUL = 2'd2;
  localparam logic [1:0] F_DONE = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic [3:0] nb, idx_r, x_r;
  logic [63:0] mask, hash_r, prod;
  ohm_pkg::cmd_t cmd_r;
  logic [7:0] kb;

  always_comb begin
    if (key_bytes == 4'd0) nb = 4'd1;
    else if (key_bytes > 4'd8) nb = 4'd8;
    else nb = key_bytes;
  end
  assign mask = ~64'd0 >> (7'd64 - {nb[3:0], 3'b000});
  assign kb = cmd_r.key[{idx_r[2:0], 3'b000} +: 8];
  assign prod = (hash_r << ohm_pkg::FNV_PRIME_SHIFT) +
                hash_r * {55'd0, ohm_pkg::FNV_PRIME_LOW};
  assign in_tready = (state_r == F_IDLE);
  assign q_valid = (state_r == F_DONE);
  assign q_cmd = cmd_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      F_IDLE: if (in_tvalid) state_nxt = (action <= ohm_pkg::ACT_DEL) ? F_XOR : F_DONE;
      F_XOR: state_nxt = F_MUL;
      F_MUL: state_nxt = (idx_r + 4'd1 == x_r) ? F_DONE : F_XOR;
      F_DONE: if (q_ready) state_nxt = F_IDLE;
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    unique case (state_r)
      F_IDLE: begin
        cmd_r.action <= action;
        cmd_r.key <= key & mask;
        cmd_r.value <= value[ohm_pkg::VALUE_WIDTH-1:0];
        cmd_r.home <= '0;
        hash_r <= ohm_pkg::FNV_BASIS;
        idx_r <= 4'd0;
        x_r <= nb;
      end
      F_XOR: begin
        hash_r <= hash_r ^ {56'd0, kb};
      end
      F_MUL: begin
        hash_r <= prod;
        cmd_r.home <= ohm_pkg::SLOT_W'(prod);
        if (idx_r + 4'd1 == x_r) idx_r <= 4'd0;
        else idx_r <= idx_r + 4'd1;
      end
      default: ;
    endcase
  end
endmodule

@@ src/ohm_back.sv @@
// Back part: probes the slot memories, updates marks, count and cursor.
// Depends on ohm_pkg and ohm_ram.
module ohm_back (
  input  logic clk,
  input  logic rst_n,
  input  logic q_valid,
  output logic q_ready,
  input  ohm_pkg::cmd_t q_cmd,
  output logic out_tvalid,
  input  logic out_tready,
  output logic [1:0] status,
  output logic [63:0] out_key,
  output logic [63:0] out_value,
  output logic [8:0] live_count
);
  localparam int SW = ohm_pkg::SLOT_W;
  localparam logic [2:0] B_IDLE = 3'd0;
  localparam logic [2:0] B_READ = 3'd1;
  localparam logic [2:0] B_EVAL = 3'd2;
  localparam logic [2:0] B_OUT = 3'd3;
  localparam logic [2:0] B_CLR = 3'd4;

  logic [2:0] state_r, state_nxt;
  ohm_pkg::cmd_t cmd_r;
  logic [SW:0] pos_r, steps_r, free_r, cursor_r, count_r;
  logic [SW-1:0] raddr;
  logic [1:0] st_r;
  logic [63:0] ok_r, ov_r;
  logic [1:0] mark_rd;
  logic [63:0] key_rd;
  logic [ohm_pkg::VALUE_WIDTH-1:0] val_rd;
  logic mwe, kwe, vwe;
  logic [SW-1:0] waddr;
  logic [1:0] mwd;
  logic [SW:0] clr_r;

  assign raddr = pos_r[SW-1:0];
  ohm_ram #(.WIDTH(2), .DEPTH(ohm_pkg::SLOTS)) u_marks (
    .clk(clk), .we(mwe), .waddr(waddr), .wdata(mwd), .raddr(raddr), .rdata(mark_rd));
  ohm_ram #(.WIDTH(64), .DEPTH(ohm_pkg::SLOTS)) u_keys (
    .clk(clk), .we(kwe), .waddr(waddr), .wdata(cmd_r.key), .raddr(raddr), .rdata(key_rd));
  ohm_ram #(.WIDTH(ohm_pkg::VALUE_WIDTH), .DEPTH(ohm_pkg::SLOTS)) u_vals (
    .clk(clk), .we(vwe), .waddr(waddr), .wdata(cmd_r.value), .raddr(raddr),
    .rdata(val_rd));

  assign q_ready = (state_r == B_IDLE);
  assign out_tvalid = (state_r == B_OUT);
  assign status = st_r;
  assign out_key = ok_r;
  assign out_value = ov_r;
  assign live_count = 9'(count_r);

  logic is_next, hit, at_end;
  logic [SW:0] ins;
  assign is_next = (cmd_r.action == ohm_pkg::ACT_NEXT);
  assign hit = (mark_rd == ohm_pkg::MARK_LIVE) && (key_rd == cmd_r.key);
  assign at_end = (steps_r == (SW+1)'(ohm_pkg::SLOTS - 1));
  assign ins = free_r[SW] ? pos_r : free_r;

  always_comb begin
    state_nxt = state_r;
    mwe = 1'b0; kwe = 1'b0; vwe = 1'b0;
    waddr = pos_r[SW-1:0];
    mwd = ohm_pkg::MARK_LIVE;
    unique case (state_r)
      B_CLR: begin
        mwe = 1'b1; waddr = clr_r[SW-1:0]; mwd = ohm_pkg::MARK_EMPTY;
        if (clr_r == (SW+1)'(ohm_pkg::SLOTS - 1)) state_nxt = B_IDLE;
      end
      B_IDLE: if (q_valid) begin
        state_nxt = (q_cmd.action == ohm_pkg::ACT_NEXT ||
                     q_cmd.action <= ohm_pkg::ACT_DEL) ? B_READ : B_OUT;
      end
      B_READ: state_nxt = (is_next && cursor_r[SW]) ? B_OUT : B_EVAL;
      B_EVAL: begin
        if (is_next) begin
          if (mark_rd == ohm_pkg::MARK_LIVE) state_nxt = B_OUT;
          else state_nxt = B_READ;
        end else if (hit) begin
          state_nxt = B_OUT;
          if (cmd_r.action == ohm_pkg::ACT_SET) vwe = 1'b1;
          if (cmd_r.action == ohm_pkg::ACT_DEL) begin
            mwe = 1'b1; mwd = ohm_pkg::MARK_TOMB;
          end
        end else if (mark_rd == ohm_pkg::MARK_EMPTY || at_end) begin
          state_nxt = B_OUT;
          if (cmd_r.action == ohm_pkg::ACT_SET &&
              (mark_rd == ohm_pkg::MARK_EMPTY || !free_r[SW] ||
               mark_rd == ohm_pkg::MARK_TOMB)) begin
            waddr = ins[SW-1:0];
            mwe = 1'b1; kwe = 1'b1; vwe = 1'b1;
          end
        end else begin
          state_nxt = B_READ;
        end
      end
      B_OUT: if (out_tready) state_nxt = B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_CLR;
      clr_r <= '0;
      count_r <= '0;
      cursor_r <= '0;
    end else begin
      state_r <= state_nxt;
      unique case (state_r)
        B_CLR: clr_r <= clr_r + 1'b1;
        B_IDLE: if (q_valid) begin
          cmd_r <= q_cmd;
          st_r <= ohm_pkg::ST_OK;
          ok_r <= '0;
          ov_r <= '0;
          steps_r <= '0;
          free_r <= (SW+1)'(ohm_pkg::SLOTS);
          if (q_cmd.action == ohm_pkg::ACT_NEXT) pos_r <= cursor_r;
          else pos_r <= {1'b0, q_cmd.home};
          if (q_cmd.action == ohm_pkg::ACT_RST) cursor_r <= '0;
        end
        B_READ: if (is_next && cursor_r[SW]) st_r <= ohm_pkg::ST_END;
        B_EVAL: begin
          if (is_next) begin
            if (mark_rd == ohm_pkg::MARK_LIVE) begin
              ok_r <= key_rd;
              ov_r <= 64'(val_rd);
            end
            cursor_r <= cursor_r + 1'b1;
            pos_r <= cursor_r + 1'b1;
          end else if (hit) begin
            if (cmd_r.action == ohm_pkg::ACT_GET) ov_r <= 64'(val_rd);
            if (cmd_r.action == ohm_pkg::ACT_DEL) count_r <= count_r - 1'b1;
          end else if (mark_rd == ohm_pkg::MARK_EMPTY || at_end) begin
            if (cmd_r.action == ohm_pkg::ACT_SET) begin
              if (mark_rd == ohm_pkg::MARK_EMPTY || !free_r[SW] ||
                  mark_rd == ohm_pkg::MARK_TOMB) begin
                count_r <= count_r + 1'b1;
              end else begin
                st_r <= ohm_pkg::ST_FULL;
              end
            end else begin
              st_r <= ohm_pkg::ST_NOTFOUND;
            end
          end else begin
            if (mark_rd == ohm_pkg::MARK_TOMB && free_r[SW]) free_r <= pos_r;
            steps_r <= steps_r + 1'b1;
            pos_r <= {1'b0, pos_r[SW-1:0] + 1'b1};
          end
        end
        default: ;
      endcase
    end
  end
endmodule

@@ src/open_addressing_hash_map.sv @@
// Top level of the open-addressing hash map: stream ports and config register.
// Depends on ohm_pkg, ohm_front and ohm_back.
// An item is hashed byte-serially (an XOR step and a multiply step per key byte,
// up to 8 bytes), handed through a one-entry queue, then probed one slot at a
// time with registered memory reads; iterator next scans the slots one at a time.
// After reset the slot marks are cleared in a pass over all 256 slots before any
// item is probed.
module open_addressing_hash_map (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  input  logic [135:0] in_tdata,   // action[2:0], key[66:3], value[130:67], zero fill
  output logic out_tvalid,
  input  logic out_tready,
  output logic [143:0] out_tdata,  // status[1:0], out_key[65:2], out_value[129:66],
                                   // live_count[138:130], zero fill
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [3:0] cfg_data
);
  logic [3:0] key_bytes_r;
  logic q_valid, q_ready;
  ohm_pkg::cmd_t q_cmd;
  logic [1:0] status;
  logic [63:0] okey, oval;
  logic [8:0] cnt;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) key_bytes_r <= 4'd8;
    else if (cfg_valid) key_bytes_r <= cfg_data;
  end

  ohm_front u_front (
    .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .action(in_tdata[2:0]), .key(in_tdata[66:3]), .value(in_tdata[130:67]),
    .key_bytes(key_bytes_r), .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd));

  ohm_back u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .status(status),
    .out_key(okey), .out_value(oval), .live_count(cnt));

  assign out_tdata = {5'd0, cnt, oval, okey, status};
endmodule
